// ===== rtl/ucs_pkg.sv =====
// ----------------------------------------------------------------------------
// ucs_pkg: shared types and constants for the up/down counter display core
// Digit layout, register indexes, key positions and the segment code table.
// ----------------------------------------------------------------------------
package ucs_pkg;

  localparam int DIGITS = 4;
  localparam int DIGIT_IDX_W = $clog2(DIGITS);
  localparam int VALUE_W = 14;
  localparam int DIV_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int KEYS = 3;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVIDE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_DIVIDE = 1'b1;

  localparam logic [DIV_W-1:0] TICK_DIVIDE_RST = 8'd5;
  localparam logic [DIV_W-1:0] REFRESH_DIVIDE_RST = 8'd25;

  // Input transaction kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_KEYS = 1'b1;

  // Key positions inside the key level vector.
  localparam int KEY_CLEAR = 0;
  localparam int KEY_UP = 1;
  localparam int KEY_DOWN = 2;

  localparam logic [7:0] SEG_BLANK = 8'hff;
  localparam logic [DIGITS-1:0] ENABLES_OFF = '1;

  typedef logic [3:0] digit_t;
  // Element 0 is the thousands digit, element DIGITS-1 the units digit.
  typedef digit_t [DIGITS-1:0] bcd_t;
  typedef logic [KEYS-1:0] key_lvl_t;

  typedef struct packed {
    logic [DIGITS-1:0] enables;
    logic [7:0] segments;
    logic led;
  } disp_out_t;

  localparam logic [7:0] SEG_CODE [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
  };

  // Common-anode code for one decimal digit; anything above nine is blank.
  function automatic logic [7:0] seg_encode(input digit_t d);
    logic [7:0] code;
    if (d < 4'd10) begin
      code = SEG_CODE[d];
    end else begin
      code = SEG_BLANK;
    end
    return code;
  endfunction

  // Decimal increment; all nines roll over to zero.
  function automatic bcd_t bcd_inc(input bcd_t d);
    bcd_t r;
    logic carry;
    r = d;
    carry = 1'b1;
    for (int k = DIGITS - 1; k >= 0; k--) begin
      if (carry) begin
        if (d[k] == 4'd9) begin
          r[k] = 4'd0;
        end else begin
          r[k] = d[k] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Decimal decrement that holds at zero.
  function automatic bcd_t bcd_dec(input bcd_t d);
    bcd_t r;
    logic borrow;
    r = d;
    borrow = (d != '0);
    for (int k = DIGITS - 1; k >= 0; k--) begin
      if (borrow) begin
        if (d[k] == 4'd0) begin
          r[k] = 4'd9;
        end else begin
          r[k] = d[k] - 4'd1;
          borrow = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/updown_counter_7seg_scan_core.sv =====
// ----------------------------------------------------------------------------
// updown_counter_7seg_scan_core: four-digit multiplexed up/down counter
// Input register, key/counter logic, display scan and result handshake.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction is either a timer tick (in_kind low) or a sample of
// the clear, up and down key levels (in_kind high). Every accepted transaction
// produces exactly one result transaction carrying the digit enables, the
// segment byte, the blink LED level and the counter value after the update.
// An accepted transaction is first loaded into the input register; when the
// result slot is free, the update logic runs it into the state registers,
// which also hold the result, and out_valid rises. Throughput is one
// transaction per cycle while out_stall stays low. While out_stall holds,
// the result and all state stay put; the input register still takes one
// more transaction, then in_stall rises until the result is taken.
// The user must write the tick_divide and refresh_divide registers through
// the cfg_ port only while the core is idle; the core does not enforce it.
// Reset loads dividers 5 and 25, clears the counter, blanks the display and
// empties both handshake stages.
// ----------------------------------------------------------------------------
module updown_counter_7seg_scan_core import ucs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic                 in_key_clear,
  input  logic                 in_key_up,
  input  logic                 in_key_down,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIGITS-1:0]    out_digit_enables,
  output logic [7:0]           out_segments,
  output logic                 out_blink_led,
  output logic [VALUE_W-1:0]   out_count_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIV_W-1:0]     cfg_data
);

  logic             in_valid_r, in_valid_nxt;
  logic             kind_r;
  key_lvl_t         keys_r;
  logic             out_valid_r, out_valid_nxt;
  logic [DIV_W-1:0] tick_divide_r;
  logic [DIV_W-1:0] refresh_divide_r;
  logic             advance;
  logic             fire;
  logic             in_accept;
  bcd_t             value_bcd;
  disp_out_t        disp;

  // The held item moves on when the result slot is empty or being drained.
  assign advance = ~out_valid_r | ~out_stall;
  assign fire = in_valid_r & advance;
  assign in_stall = in_valid_r & ~advance;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_kind;
      keys_r[KEY_CLEAR] <= in_key_clear;
      keys_r[KEY_UP] <= in_key_up;
      keys_r[KEY_DOWN] <= in_key_down;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_divide_r <= TICK_DIVIDE_RST;
      refresh_divide_r <= REFRESH_DIVIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK_DIVIDE: tick_divide_r <= cfg_data;
        REG_REFRESH_DIVIDE: refresh_divide_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ucs_keys u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample    (fire && kind_r == KIND_KEYS),
    .key_lvl   (keys_r),
    .value     (out_count_value),
    .value_bcd (value_bcd)
  );

  ucs_display u_display (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (fire && kind_r == KIND_TICK),
    .tick_divide    (tick_divide_r),
    .refresh_divide (refresh_divide_r),
    .value_bcd      (value_bcd),
    .disp           (disp)
  );

  assign out_valid = out_valid_r;
  assign out_digit_enables = disp.enables;
  assign out_segments = disp.segments;
  assign out_blink_led = disp.led;

endmodule

// ===== rtl/ucs_keys.sv =====
// ----------------------------------------------------------------------------
// ucs_keys: key edge detection and counter value
// Keeps the counter in binary and in decimal digits side by side.
// ----------------------------------------------------------------------------
module ucs_keys import ucs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sample,
  input  key_lvl_t           key_lvl,
  output logic [VALUE_W-1:0] value,
  output bcd_t               value_bcd
);

  logic [VALUE_W-1:0] value_r, value_nxt;
  bcd_t               bcd_r, bcd_nxt;
  key_lvl_t           armed_r;
  key_lvl_t           fire;

  // A key acts when it was armed by an earlier high sample and is now low.
  assign fire = armed_r & ~key_lvl;

  // Keys act in the order clear, up, down, each on the value left before it.
  always_comb begin
    value_nxt = value_r;
    bcd_nxt = bcd_r;
    if (fire[KEY_CLEAR]) begin
      value_nxt = '0;
      bcd_nxt = '0;
    end
    if (fire[KEY_UP]) begin
      bcd_nxt = bcd_inc(bcd_nxt);
      if (value_nxt >= VALUE_MAX) begin
        value_nxt = '0;
      end else begin
        value_nxt = value_nxt + 14'd1;
      end
    end
    if (fire[KEY_DOWN]) begin
      bcd_nxt = bcd_dec(bcd_nxt);
      if (value_nxt != '0) begin
        value_nxt = value_nxt - 14'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      bcd_r <= '0;
      armed_r <= '0;
    end else if (sample) begin
      value_r <= value_nxt;
      bcd_r <= bcd_nxt;
      armed_r <= key_lvl;
    end
  end

  assign value = value_r;
  assign value_bcd = bcd_r;

endmodule

// ===== rtl/ucs_display.sv =====
// ----------------------------------------------------------------------------
// ucs_display: tick prescaler and digit scan
// Drives one digit per display step and latches the shown digits.
// ----------------------------------------------------------------------------
module ucs_display import ucs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic [DIV_W-1:0] tick_divide,
  input  logic [DIV_W-1:0] refresh_divide,
  input  bcd_t             value_bcd,
  output disp_out_t        disp
);

  logic [DIV_W-1:0]       tick_count_r, tick_count_nxt;
  logic [DIV_W-1:0]       refresh_count_r, refresh_count_nxt;
  logic [DIGIT_IDX_W-1:0] digit_index_r, digit_index_nxt;
  bcd_t                   shown_r, shown_nxt;
  disp_out_t              disp_r, disp_nxt;
  logic [DIV_W-1:0]       tick_inc;
  logic [DIV_W-1:0]       refresh_inc;

  assign tick_inc = tick_count_r + 8'd1;
  assign refresh_inc = refresh_count_r + 8'd1;

  always_comb begin
    tick_count_nxt = tick_count_r;
    refresh_count_nxt = refresh_count_r;
    digit_index_nxt = digit_index_r;
    shown_nxt = shown_r;
    disp_nxt = disp_r;
    if (tick) begin
      tick_count_nxt = tick_inc;
      // The counters wrap at 256, so a lowered divider fires after the wrap.
      if (tick_inc == tick_divide) begin
        tick_count_nxt = '0;
        disp_nxt.enables = ~(4'b0001 << digit_index_r);
        disp_nxt.segments = seg_encode(shown_r[digit_index_r]);
        disp_nxt.led = ~disp_r.led;
        digit_index_nxt = digit_index_r + 2'd1;
        refresh_count_nxt = refresh_inc;
        if (refresh_inc == refresh_divide) begin
          refresh_count_nxt = '0;
          shown_nxt = value_bcd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      refresh_count_r <= '0;
      digit_index_r <= '0;
      shown_r <= '0;
      disp_r.enables <= ENABLES_OFF;
      disp_r.segments <= SEG_BLANK;
      disp_r.led <= 1'b0;
    end else begin
      tick_count_r <= tick_count_nxt;
      refresh_count_r <= refresh_count_nxt;
      digit_index_r <= digit_index_nxt;
      shown_r <= shown_nxt;
      disp_r <= disp_nxt;
    end
  end

  assign disp = disp_r;

endmodule

// ===== rtl/ucs_checker.sv =====
// ----------------------------------------------------------------------------
// ucs_checker: port-level checks for the up/down counter display core
// Watches the top-level ports and is attached to the core by a bind.
// ----------------------------------------------------------------------------
module ucs_checker import ucs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DIGITS-1:0]    out_digit_enables,
  input logic [7:0]           out_segments,
  input logic                 out_blink_led,
  input logic [VALUE_W-1:0]   out_count_value
);

  // The counter never leaves the four-digit decimal range.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_count_value <= VALUE_MAX)
    else $error("count value above 9999");

  // At most one digit is driven at a time.
  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(~out_digit_enables))
    else $error("more than one digit enabled");

  // The display is blank exactly while no digit has been driven yet.
  a_blank_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_digit_enables == ENABLES_OFF) == (out_segments == SEG_BLANK))
    else $error("blank segments do not match digit enables");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count_value)
      && $stable(out_segments) && $stable(out_blink_led))
    else $error("stalled result changed");

endmodule

bind updown_counter_7seg_scan_core ucs_checker u_ucs_checker (.*);
